### rtl/usan_pkg.sv
// usan_pkg: shared types, constants and byte-classification helpers
// for the UTF-8 sanitizer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usan_pkg;

  // Command queue between the front and the back part.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Leads with narrowed second-byte bounds
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  // Continuation bounds
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] CONT_E0_LO = 8'hA0;
  localparam logic [7:0] CONT_ED_HI = 8'h9F;
  localparam logic [7:0] CONT_F0_LO = 8'h90;
  localparam logic [7:0] CONT_F4_HI = 8'h8F;

  localparam logic [7:0] ASCII_HI = 8'h7F;

  // One output run: rep_cnt replacements, then lit_cnt literal bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;  // 0..4
    logic [2:0]      lit_cnt;  // 0..4
    logic [3:0][7:0] lit;
    logic            last;     // run closes the message
  } cmd_t;

  // Sequence length for a lead byte, 0 when it cannot lead.
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c >= LEAD2_LO && c <= LEAD2_HI) len = 3'd2;
    else if (c >= LEAD3_LO && c <= LEAD3_HI) len = 3'd3;
    else if (c >= LEAD4_LO && c <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

  // Byte of the replacement character by position.
  function automatic logic [7:0] repl_byte(input logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/usan_in_if.sv
// usan_in_if: input byte channel (valid/ready plus byte and end flag).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface usan_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

### rtl/usan_out_if.sv
// usan_out_if: sanitized output byte channel (valid/ready plus byte and flags).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface usan_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_end,
                  output ready);
endinterface

`default_nettype wire

### rtl/usan_front.sv
// usan_front: accepts input bytes, tracks the pending sequence and emits a run
// command for each byte that produces output. Depends on usan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usan_front import usan_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic [1:0]      held_cnt_q;
  logic [1:0]      held_cnt_d;
  logic [2:0][7:0] held_q;
  logic [2:0][7:0] held_d;

  logic       accept;
  logic [2:0] need;
  logic [2:0] lead_len;
  logic [2:0] nxt_cnt;
  logic [7:0] lo;
  logic [7:0] hi;
  logic       cont_ok;
  logic       complete;
  cmd_t       cmd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    need     = seq_len(held_q[0]);
    lead_len = seq_len(in_byte_i);
    lo       = CONT_LO;
    hi       = CONT_HI;
    if (held_cnt_q == 2'd1) begin
      case (held_q[0])
        LEAD_E0: lo = CONT_E0_LO;
        LEAD_ED: hi = CONT_ED_HI;
        LEAD_F0: lo = CONT_F0_LO;
        LEAD_F4: hi = CONT_F4_HI;
        default: ;
      endcase
    end
    cont_ok  = (held_cnt_q != 2'd0) && (need != 3'd0) && ({1'b0, held_cnt_q} < need) &&
               (in_byte_i >= lo) && (in_byte_i <= hi);
    complete = cont_ok && (({1'b0, held_cnt_q} + 3'd1) == need);

    held_d      = held_q;
    nxt_cnt     = {1'b0, held_cnt_q};
    cmd.rep_cnt = 3'd0;
    cmd.lit_cnt = 3'd0;
    cmd.lit     = {4{in_byte_i}};
    cmd.last    = in_last_i;

    if (complete) begin
      // held bytes plus this one go out verbatim
      cmd.lit[0]  = held_q[0];
      cmd.lit[1]  = (held_cnt_q >= 2'd2) ? held_q[1] : in_byte_i;
      cmd.lit[2]  = (held_cnt_q == 2'd3) ? held_q[2] : in_byte_i;
      cmd.lit_cnt = nxt_cnt + 3'd1;
      nxt_cnt     = 3'd0;
    end else if (cont_ok) begin
      held_d[held_cnt_q] = in_byte_i;
      nxt_cnt            = nxt_cnt + 3'd1;
    end else begin
      // failed (or empty) sequence: replace what is held, judge byte as lead
      cmd.rep_cnt = {1'b0, held_cnt_q};
      nxt_cnt     = 3'd0;
      if (in_byte_i <= ASCII_HI) begin
        cmd.lit_cnt = 3'd1;
      end else if (lead_len == 3'd0) begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end else begin
        held_d[0] = in_byte_i;
        nxt_cnt   = 3'd1;
      end
    end

    if (in_last_i) begin
      cmd.rep_cnt = cmd.rep_cnt + nxt_cnt;
      nxt_cnt     = 3'd0;
    end
    held_cnt_d = nxt_cnt[1:0];
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.rep_cnt != 3'd0) || (cmd.lit_cnt != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  // end of message always leaves nothing held and always produces output
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (held_cnt_q == 2'd0))
    else $error("held bytes left after message end");
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |-> push_o)
    else $error("message end produced no output run");

endmodule

`default_nettype wire

### rtl/usan_cmd_fifo.sv
// usan_cmd_fifo: short register queue of run commands between front and back.
// Depends on usan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usan_cmd_fifo import usan_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q;
  logic [CMD_PTR_W-1:0] rd_ptr_q;
  logic [CMD_CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CMD_CNT_W'(CMD_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CMD_CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");

endmodule

`default_nettype wire

### rtl/usan_back.sv
// usan_back: expands the head run command into bytes, one per cycle while
// the output is ready, via a registered output stage. Depends on usan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usan_back import usan_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  head_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       message_end_o
);

  logic [2:0] rep_idx_q;
  logic [2:0] rep_idx_d;
  logic [1:0] phase_q;
  logic [1:0] phase_d;
  logic [1:0] lit_idx_q;
  logic [1:0] lit_idx_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic [7:0] byte_q;
  logic       run_last_q;
  logic       msg_end_q;

  logic       step;
  logic       in_rep;
  logic       final_b;
  logic [7:0] byte_d;

  assign step = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    in_rep    = rep_idx_q < head_i.rep_cnt;
    rep_idx_d = rep_idx_q;
    phase_d   = phase_q;
    lit_idx_d = lit_idx_q;
    if (in_rep) begin
      byte_d  = repl_byte(phase_q);
      final_b = (phase_q == 2'd2) && ((rep_idx_q + 3'd1) == head_i.rep_cnt) &&
                (head_i.lit_cnt == 3'd0);
      if (phase_q == 2'd2) begin
        phase_d   = 2'd0;
        rep_idx_d = rep_idx_q + 3'd1;
      end else begin
        phase_d = phase_q + 2'd1;
      end
    end else begin
      byte_d    = head_i.lit[lit_idx_q];
      final_b   = (({1'b0, lit_idx_q} + 3'd1) == head_i.lit_cnt);
      lit_idx_d = lit_idx_q + 2'd1;
    end
    if (final_b) begin
      rep_idx_d = 3'd0;
      phase_d   = 2'd0;
      lit_idx_d = 2'd0;
    end
  end

  assign pop_o = step && final_b;

  always_comb begin
    if (out_valid_q && !out_ready_i) out_valid_d = 1'b1;
    else                             out_valid_d = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_idx_q   <= 3'd0;
      phase_q     <= 2'd0;
      lit_idx_q   <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        rep_idx_q <= rep_idx_d;
        phase_q   <= phase_d;
        lit_idx_q <= lit_idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q     <= byte_d;
      run_last_q <= final_b;
      msg_end_q  <= final_b && head_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = run_last_q;
  assign message_end_o = msg_end_q;

  // counters stay inside the head run
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (rep_idx_q <= head_i.rep_cnt) && (phase_q != 2'd3))
    else $error("replacement counter beyond run");

endmodule

`default_nettype wire

### rtl/utf8_sanitizer.sv
// utf8_sanitizer: top level of the streaming UTF-8 sanitizer.
// Depends on usan_pkg, usan_in_if, usan_out_if, usan_front, usan_cmd_fifo, usan_back.
// An input transfer's run command is registered in the queue, then its bytes in the output stage.
// Throughput: one input byte per cycle while the output keeps up; an item producing N
//   bytes (0..12) goes out one byte per cycle while the output is ready, from the back part.
// Reset (rst_ni low, async): no held bytes, command queue empty, no output valid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_sanitizer import usan_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  usan_in_if.sink     in_i,
  usan_out_if.source  out_o
);

  // Front to queue: one run command per input transfer that produces output.
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to back: the head command and its pop.
  cmd_t head;
  logic empty;
  logic pop;

  // Front part: holds the partial sequence (lead plus up to two continuation
  // bytes) and classifies each byte. Stalls only when the queue is full, so it
  // keeps taking bytes while the output side drains replacements.
  usan_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Short command queue decoupling byte intake from run expansion.
  usan_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  // Back part: replacements first (EF BF BD each), then literal bytes, into
  // a registered output stage that advances on every transfer.
  usan_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .run_last_o    (out_o.run_last),
    .message_end_o (out_o.message_end)
  );

endmodule

`default_nettype wire
